// ----- hw/rtl/ilte_pkg.sv -----
package ilte_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int IDX_W   = 6;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 7;
    localparam int REQ_W   = 3;

    // Request codes as they arrive on req_type.
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 3'd1;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        K_FIND,
        K_MODIFY,
        K_APPEND,
        K_CLEAR,
        K_REMOVE,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   pos;
        logic [VAL_W-1:0]   val;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FIND,
        BK_MODIFY,
        BK_REMOVE
    } bk_state_t;

    localparam logic [1:0] Q_DEPTH = 2'd2;

endpackage

// ----- hw/rtl/ilte_front.sv -----
module ilte_front
    import ilte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [IDX_W-1:0]   entry_index,
    input  logic [VAL_W-1:0]   data_value,
    output logic               cmd_valid,
    output cmd_t               cmd,
    input  logic               cmd_pop
);

    cmd_t       q_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    cmd_t       decoded;

    always_comb
    begin
        decoded.pos = entry_index;
        decoded.val = data_value;
        case (req_type)
            REQ_FIND:   decoded.kind = K_FIND;
            REQ_MODIFY: decoded.kind = K_MODIFY;
            REQ_APPEND: decoded.kind = K_APPEND;
            REQ_CLEAR:  decoded.kind = K_CLEAR;
            REQ_REMOVE: decoded.kind = K_REMOVE;
            default:    decoded.kind = K_NOP;
        endcase
    end

    assign in_ready  = (fill_reg != Q_DEPTH);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= decoded;
        end
    end

endmodule

// ----- hw/rtl/ilte_back.sv -----
module ilte_back
    import ilte_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [IDX_W-1:0]    found_index,
    output logic [VAL_W-1:0]    old_value,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > IDX_W) ? CW : IDX_W;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;
    logic [AW-1:0]    raddr;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;

    bk_state_t        state_reg;
    bk_state_t        state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    idx_next;
    logic [AW-1:0]    pos_reg;
    logic [AW-1:0]    pos_next;
    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [IDX_W-1:0]    found_reg;
    logic [VAL_W-1:0]    old_reg;
    logic [COUNT_W-1:0]  ocount_reg;

    logic                load;
    status_t             res_status;
    logic [IDX_W-1:0]    res_found;
    logic [VAL_W-1:0]    res_old;

    logic             out_free;
    logic             pos_ok;
    logic             pos_last;
    logic             scan_last;

    // The output register is only written by this unit, so once it is free
    // at dispatch it stays free until the dispatched request finishes.
    assign out_free  = !out_valid_reg || out_ready;
    assign pos_ok    = MW'(cmd.pos) < MW'(count_reg);
    assign pos_last  = (MW'(cmd.pos) + MW'(1)) == MW'(count_reg);
    assign scan_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        raddr      = '0;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        cmd_pop    = 1'b0;
        load       = 1'b0;
        res_status = ST_OK;
        res_found  = '0;
        res_old    = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        K_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                load       = 1'b1;
                                res_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                raddr      = '0;
                                idx_next   = '0;
                                val_next   = cmd.val;
                                state_next = BK_FIND;
                            end
                        end
                        K_MODIFY:
                        begin
                            if (pos_ok)
                            begin
                                raddr      = AW'(cmd.pos);
                                pos_next   = AW'(cmd.pos);
                                val_next   = cmd.val;
                                state_next = BK_MODIFY;
                            end
                            else
                            begin
                                load       = 1'b1;
                                res_status = ST_BAD_INDEX;
                            end
                        end
                        K_APPEND:
                        begin
                            load = 1'b1;
                            if (count_reg < CW'(DEPTH))
                            begin
                                we         = 1'b1;
                                waddr      = AW'(count_reg);
                                wdata      = cmd.val;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                res_status = ST_FULL;
                            end
                        end
                        K_CLEAR:
                        begin
                            load = 1'b1;
                            if (pos_ok)
                            begin
                                we    = 1'b1;
                                waddr = AW'(cmd.pos);
                                wdata = '0;
                            end
                            else
                            begin
                                res_status = ST_BAD_INDEX;
                            end
                        end
                        K_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                load       = 1'b1;
                                res_status = ST_BAD_INDEX;
                            end
                            else if (pos_last)
                            begin
                                load       = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                raddr      = AW'(MW'(cmd.pos) + MW'(1));
                                idx_next   = AW'(MW'(cmd.pos) + MW'(1));
                                state_next = BK_REMOVE;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end

            BK_FIND:
            begin
                // rdata_reg holds the entry at idx_reg, read in the last cycle.
                if (rdata_reg == val_reg)
                begin
                    load       = 1'b1;
                    res_found  = IDX_W'(idx_reg);
                    state_next = BK_IDLE;
                end
                else if (scan_last)
                begin
                    load       = 1'b1;
                    res_status = ST_NOT_FOUND;
                    state_next = BK_IDLE;
                end
                else
                begin
                    raddr    = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end

            BK_MODIFY:
            begin
                load       = 1'b1;
                res_old    = rdata_reg;
                we         = 1'b1;
                waddr      = pos_reg;
                wdata      = val_reg;
                state_next = BK_IDLE;
            end

            BK_REMOVE:
            begin
                // Move the entry read last cycle down by one place.
                we    = 1'b1;
                waddr = idx_reg - AW'(1);
                wdata = rdata_reg;
                if (scan_last)
                begin
                    load       = 1'b1;
                    count_next = count_reg - CW'(1);
                    state_next = BK_IDLE;
                end
                else
                begin
                    raddr    = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        if (load)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            old_reg    <= res_old;
            ocount_reg <= COUNT_W'(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign old_value   = old_reg;
    assign entry_count = ocount_reg;

endmodule

// ----- hw/rtl/indexed_list_table_engine_top.sv -----
// Indexed list table engine: a packed list of signed 32-bit words plus a count.
// Requests come in on the in_valid/in_ready channel (req_type, entry_index,
// data_value); each request produces exactly one result transfer on the
// out_valid/out_ready channel (status, found_index, old_value, entry_count).
// Requests land in a two-entry queue and are carried out in order by a
// sequencer that owns the entry memory (one write and one read port).
// Append, clear, unknown codes and any request rejected by its checks finish
// as soon as the sequencer takes them; modify reads the entry and then writes
// it; find scans from position 0 until a match or the end of the list, and
// remove shifts each entry above the index down by one place.
// Find and remove touch one entry per cycle through the memory read port, so
// a long find or remove holds the sequencer until its scan is done.
// Short requests run at one per cycle while the receiver keeps out_ready high.
// At reset the list is empty and both channels are idle; memory contents are
// not cleared, since only entries below the count are ever read.
// When the receiver stalls, the result stays in the output register and the
// sequencer holds the next request at the head of the queue; the queue takes
// one more behind it and then drops in_ready.
module indexed_list_table_engine_top
    import ilte_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [IDX_W-1:0]    entry_index,
    input  logic signed [VAL_W-1:0] data_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [IDX_W-1:0]    found_index,
    output logic signed [VAL_W-1:0] old_value,
    output logic [COUNT_W-1:0]  entry_count
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    ilte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .data_value  (data_value),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    ilte_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_index (found_index),
        .old_value   (old_value),
        .entry_count (entry_count)
    );

endmodule

// ----- hw/rtl/ilte_checker.sv -----
module ilte_checker
    import ilte_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          status,
    input logic [IDX_W-1:0]    found_index,
    input logic [VAL_W-1:0]    old_value,
    input logic [COUNT_W-1:0]  entry_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(found_index) && $stable(old_value) && $stable(entry_count))
        else $error("result changed or dropped while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= DEPTH)
        else $error("entry count beyond table depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == COUNT_W'(DEPTH))
        else $error("table full reported with room left");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> found_index == '0 && old_value == '0)
        else $error("failed request returned nonzero data");

endmodule

bind indexed_list_table_engine_top ilte_checker #(.DEPTH(DEPTH)) u_ilte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .old_value   (old_value),
    .entry_count (entry_count)
);

// ----- sim/ilte_list_checker.sv -----
module ilte_list_checker
    import ilte_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [VAL_W-1:0] data_value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [1:0]              status,
    input  logic [IDX_W-1:0]        found_index,
    input  logic signed [VAL_W-1:0] old_value,
    input  logic [COUNT_W-1:0]      entry_count,
    output int                      errors,
    output int                      pending,
    output int                      compared
);

    typedef struct packed {
        status_t              st;
        logic [IDX_W-1:0]     found;
        logic [VAL_W-1:0]     old;
        logic [COUNT_W-1:0]   count;
    } list_result_t;

    // Shadow copy of the list; only entries below list_len are meaningful.
    logic [VAL_W-1:0] list_words [DEPTH];
    int               list_len;
    list_result_t     expected_results [$];

    function automatic list_result_t apply_request(input logic [REQ_W-1:0] op,
                                                   input logic [IDX_W-1:0] pos,
                                                   input logic [VAL_W-1:0] val);
        list_result_t r;
        int i;
        r.st    = ST_OK;
        r.found = '0;
        r.old   = '0;
        case (op)
            REQ_FIND:
            begin
                r.st = ST_NOT_FOUND;
                for (i = 0; i < list_len; i++)
                begin
                    if (r.st == ST_NOT_FOUND && list_words[i] == val)
                    begin
                        r.st    = ST_OK;
                        r.found = IDX_W'(i);
                    end
                end
            end
            REQ_MODIFY:
            begin
                if (int'(pos) < list_len)
                begin
                    r.old           = list_words[pos];
                    list_words[pos] = val;
                end
                else
                    r.st = ST_BAD_INDEX;
            end
            REQ_APPEND:
            begin
                if (list_len < DEPTH)
                begin
                    list_words[list_len] = val;
                    list_len++;
                end
                else
                    r.st = ST_FULL;
            end
            REQ_CLEAR:
            begin
                if (int'(pos) < list_len)
                    list_words[pos] = '0;
                else
                    r.st = ST_BAD_INDEX;
            end
            REQ_REMOVE:
            begin
                if (int'(pos) < list_len)
                begin
                    for (i = int'(pos); i < list_len - 1; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
                else
                    r.st = ST_BAD_INDEX;
            end
            default:
            begin
                // Unused request codes leave the list alone.
            end
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [VAL_W-1:0] exp_val,
                                input logic [VAL_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t exp_res;
        if (!rst_n)
        begin
            list_len = 0;
            expected_results.delete();
        end
        else
        begin
            // Check the outgoing transfer before predicting the incoming one, so a
            // result can never be matched against a request taken at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with no request outstanding, status %0d",
                             $time, status);
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    report_field("status", VAL_W'(exp_res.st), VAL_W'(status));
                    report_field("found_index", VAL_W'(exp_res.found), VAL_W'(found_index));
                    report_field("old_value", exp_res.old, old_value);
                    report_field("entry_count", VAL_W'(exp_res.count), VAL_W'(entry_count));
                    compared++;
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_request(req_type, entry_index, data_value));
        end
        pending = expected_results.size();
    end

endmodule

// ----- sim/tb.sv -----
module tb;
    import ilte_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int POOL_SIZE     = 12;
    localparam int SETTLE_CYCLES = 100;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [REQ_W-1:0]        req_type = REQ_FIND;
    logic [IDX_W-1:0]        entry_index = '0;
    logic signed [VAL_W-1:0] data_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              status;
    logic [IDX_W-1:0]        found_index;
    logic signed [VAL_W-1:0] old_value;
    logic [COUNT_W-1:0]      entry_count;

    int errors;
    int pending;
    int compared;
    int cycles = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Occupancy as the stimulus sees it, used to aim positions and to count full appends and bad positions.
    int list_count = 0;
    int full_hits = 0;
    int bad_index_hits = 0;
    int op_issued [6];
    logic [VAL_W-1:0] value_pool [POOL_SIZE];

    indexed_list_table_engine_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_index (found_index),
        .old_value   (old_value),
        .entry_count (entry_count)
    );

    ilte_list_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_index (found_index),
        .old_value   (old_value),
        .entry_count (entry_count),
        .errors      (errors),
        .pending     (pending),
        .compared    (compared)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= op;
        entry_index <= pos;
        data_value  <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        op_issued[(op <= REQ_REMOVE) ? int'(op) : 5]++;
        case (op)
            REQ_APPEND:
            begin
                if (list_count < DEPTH_DEFAULT)
                    list_count++;
                else
                    full_hits++;
            end
            REQ_MODIFY, REQ_CLEAR, REQ_REMOVE:
            begin
                if (int'(pos) >= list_count)
                    bad_index_hits++;
                else if (op == REQ_REMOVE)
                    list_count--;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_for_results;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        int k;
        int phase;
        int r;
        logic [REQ_W-1:0] op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        // Cumulative weights per phase: append, find, modify, clear, remove.
        int weights [3][5];

        weights = '{'{70, 80, 86, 90, 95},   // filling
                    '{15, 30, 40, 48, 93},   // draining
                    '{32, 55, 70, 78, 95}};  // mixed
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (k = 4; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-list cases, extreme values, duplicates, unused codes.
        send_request(REQ_FIND, 6'd0, 32'h0000_0000);
        send_request(REQ_MODIFY, 6'd0, 32'h1234_5678);
        send_request(REQ_CLEAR, 6'd0, 32'h0000_0000);
        send_request(REQ_REMOVE, 6'd63, 32'h0000_0000);
        send_request(REQ_APPEND, 6'd0, 32'h8000_0000);
        send_request(REQ_APPEND, 6'd63, 32'h7fff_ffff);
        send_request(REQ_APPEND, 6'd0, 32'h0000_0000);
        send_request(REQ_APPEND, 6'd0, 32'hffff_ffff);
        send_request(REQ_APPEND, 6'd0, 32'h7fff_ffff);
        send_request(REQ_FIND, 6'd0, 32'h7fff_ffff);
        send_request(REQ_FIND, 6'd0, 32'h0001_2345);
        send_request(REQ_MODIFY, 6'd3, 32'h8000_0000);
        send_request(REQ_MODIFY, 6'd5, 32'h5555_aaaa);
        send_request(REQ_CLEAR, 6'd0, 32'hffff_ffff);
        send_request(REQ_FIND, 6'd0, 32'h0000_0000);
        send_request(REQ_REMOVE, 6'd0, 32'h0000_0000);
        send_request(REQ_REMOVE, 6'd3, 32'h0000_0000);
        send_request(REQ_REMOVE + 3'd1, 6'd63, 32'hffff_ffff);
        send_request(REQ_REMOVE + 3'd2, 6'd21, 32'haaaa_5555);
        send_request({REQ_W{1'b1}}, 6'd42, 32'h5555_aaaa);
        send_request(REQ_MODIFY, 6'd63, 32'h0000_0001);
        send_request(REQ_FIND, 6'd0, 32'h8000_0000);
        wait_for_results();

        k = 0;
        while (k < RANDOM_ITEMS)
        begin
            phase = (k / 150) % 3;
            case ((k / 100) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase

            r = $urandom_range(0, 99);
            if (r < weights[phase][0])
                op = REQ_APPEND;
            else if (r < weights[phase][1])
                op = REQ_FIND;
            else if (r < weights[phase][2])
                op = REQ_MODIFY;
            else if (r < weights[phase][3])
                op = REQ_CLEAR;
            else if (r < weights[phase][4])
                op = REQ_REMOVE;
            else
                op = REQ_W'($urandom_range(REQ_REMOVE + 1, {REQ_W{1'b1}}));

            if (list_count > 0 && $urandom_range(0, 99) < 85)
                idx = IDX_W'($urandom_range(0, list_count - 1));
            else
                idx = IDX_W'($urandom);

            // Pool values make finds hit and leave duplicates in the list.
            if ($urandom_range(0, 99) < ((op == REQ_FIND) ? 80 : 60))
                val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                val = $urandom;

            send_request(op, idx, val);
            if (op <= REQ_REMOVE)
            begin
                k++;
                if (k % 200 == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Requests: %0d find, %0d modify, %0d append, %0d clear, %0d remove, %0d unused",
                 op_issued[0], op_issued[1], op_issued[2], op_issued[3], op_issued[4],
                 op_issued[5]);
        $display("%0d results compared; %0d appends to a full list, %0d out-of-range positions",
                 compared, full_hits, bad_index_hits);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
